// ===== rtl/mrsb_pkg.sv =====
`default_nettype none
package mrsb_pkg;
    localparam int FIELD_W = 63;

    typedef struct packed {
        logic [FIELD_W-1:0] candidate;
        logic [FIELD_W-1:0] base;
    } mrsb_req_t;

    typedef struct packed {
        logic               probable_prime;
        logic [FIELD_W-1:0] last_residue;
    } mrsb_res_t;

    // Control between sequencer and the modular multiplier.
    typedef struct packed {
        logic start;
    } mrsb_mul_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/mrsb_modmul.sv =====
`default_nettype none
// Bit-serial double-and-add modular multiplier: one bit of b per cycle.
module mrsb_modmul #(
    parameter int W = 63
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mrsb_pkg::mrsb_mul_ctl_t ctl,
    input  wire logic [W-1:0]          a,
    input  wire logic [W-1:0]          b,
    input  wire logic [W-1:0]          n,
    output logic                       done,
    output logic [W-1:0]               r
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  b_reg, b_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    dbl, dred, add, ared;

    // One step: double, reduce, conditionally add, reduce.
    always_comb
    begin
        dbl  = {r_reg, 1'b0};
        dred = (dbl >= {1'b0, n}) ? dbl - {1'b0, n} : dbl;
        add  = b_reg[W-1] ? dred + {1'b0, a} : dred;
        ared = (add >= {1'b0, n}) ? add - {1'b0, n} : add;
        r_next    = r_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            r_next    = '0;
            b_next    = b;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            r_next   = ared[W-1:0];
            b_next   = {b_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        b_reg <= b_next;
    end

    assign done = done_reg;
    assign r    = r_reg;
endmodule
`default_nettype wire

// ===== rtl/miller_rabin_single_base.sv =====
`default_nettype none
// Channel   Direction  Handshake               Payload
// request   in         start high, busy low    mrsb_req_t  (candidate, base)
// result    out        done strobe, one cycle  mrsb_res_t  (probable_prime, last_residue)
//
// One request runs in steps: splitting n-1 shifts out its trailing zeros,
// the base is reduced by restoring subtraction, and each modular product
// runs as issue, load, MODULUS_BITS steps and result in the shared
// bit-serial multiplier. A test needs at most 2*MODULUS_BITS-1 products.
// Reset clears the sequencer; busy stays high from acceptance to the strobe.
// The receiver cannot stall: done is high for a single cycle; the result holds until the next request is accepted.
module miller_rabin_single_base #(
    parameter int MODULUS_BITS = 63
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire mrsb_pkg::mrsb_req_t request,
    output logic                     busy,
    output logic                     done,
    output mrsb_pkg::mrsb_res_t      result
);
    localparam int W  = MODULUS_BITS;
    localparam int FW = mrsb_pkg::FIELD_W;
    localparam int BW = $clog2(W + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SPLIT, S_RED, S_SQ, S_SQW, S_ML, S_MLW, S_CHK, S_LSQ, S_LSQW, S_OUT
    } state_t;

    state_t        state_reg;
    logic [W-1:0]  n_reg, a_reg, q_reg, y_reg, nm1_reg;
    logic [W-1:0]  ra_reg;
    logic [BW-1:0] k_reg, i_reg, bit_reg;
    logic          pass_reg, done_reg;
    logic [BW:0]   rcnt_reg;
    logic [W-1:0]  ma_reg, mb_reg;
    mrsb_pkg::mrsb_mul_ctl_t mctl_reg;
    logic          mdone;
    logic [W-1:0]  mr;
    logic [W:0]    rtry;
    logic [W-1:0]  nin, ain;
    logic [W-1:0]  one;

    assign nin = request.candidate[W-1:0];
    assign ain = request.base[W-1:0];
    assign one = W'(1);
    assign rtry = {ra_reg, a_reg[W-1]} - {1'b0, n_reg};

    mrsb_modmul #(.W(W)) u_mul (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (mctl_reg),
        .a    (ma_reg),
        .b    (mb_reg),
        .n    (n_reg),
        .done (mdone),
        .r    (mr)
    );

    // Sequencer: reject small or even candidates, split n-1, reduce base, square-and-multiply, square loop.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            mctl_reg  <= '0;
        end
        else
        begin
            done_reg  <= 1'b0;
            mctl_reg  <= '0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        n_reg   <= nin;
                        a_reg   <= ain;
                        nm1_reg <= nin - one;
                        q_reg   <= nin - one;
                        k_reg   <= '0;
                        ra_reg  <= '0;
                        rcnt_reg <= (BW+1)'(W);
                        pass_reg <= 1'b0;
                        if (nin < W'(3) || !nin[0])
                        begin
                            y_reg     <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                            state_reg <= S_SPLIT;
                    end
                end
                // Shift out trailing zeros of n-1, one per cycle.
                S_SPLIT:
                begin
                    if (!q_reg[0])
                    begin
                        q_reg <= q_reg >> 1;
                        k_reg <= k_reg + 1'b1;
                    end
                    else
                        state_reg <= S_RED;
                end
                // Restoring reduction of the base, one bit per cycle.
                S_RED:
                begin
                    if (rcnt_reg == '0)
                    begin
                        a_reg     <= ra_reg;
                        y_reg     <= one;
                        bit_reg   <= BW'(W - 1);
                        state_reg <= S_SQ;
                    end
                    else
                    begin
                        ra_reg   <= rtry[W] ? {ra_reg[W-2:0], a_reg[W-1]} : rtry[W-1:0];
                        a_reg    <= {a_reg[W-2:0], 1'b0};
                        rcnt_reg <= rcnt_reg - 1'b1;
                    end
                end
                S_SQ:
                begin
                    ma_reg    <= y_reg;
                    mb_reg    <= y_reg;
                    mctl_reg  <= '{start: 1'b1};
                    state_reg <= S_SQW;
                end
                S_SQW:
                begin
                    if (mdone)
                    begin
                        y_reg <= mr;
                        if (q_reg[bit_reg])
                        begin
                            ma_reg    <= mr;
                            mb_reg    <= a_reg;
                            mctl_reg  <= '{start: 1'b1};
                            state_reg <= S_MLW;
                        end
                        else
                            state_reg <= S_ML;
                    end
                end
                S_MLW:
                begin
                    if (mdone)
                    begin
                        y_reg     <= mr;
                        state_reg <= S_ML;
                    end
                end
                // Advance to the next exponent bit, or to the check after the last bit.
                S_ML:
                begin
                    if (bit_reg == '0)
                    begin
                        i_reg     <= BW'(1);
                        state_reg <= S_CHK;
                    end
                    else
                    begin
                        bit_reg   <= bit_reg - 1'b1;
                        state_reg <= S_SQ;
                    end
                end
                S_CHK:
                begin
                    if (y_reg == one || y_reg == nm1_reg)
                    begin
                        pass_reg  <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else if (i_reg >= k_reg)
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_LSQ;
                end
                S_LSQ:
                begin
                    ma_reg    <= y_reg;
                    mb_reg    <= y_reg;
                    mctl_reg  <= '{start: 1'b1};
                    state_reg <= S_LSQW;
                end
                S_LSQW:
                begin
                    if (mdone)
                    begin
                        y_reg <= mr;
                        i_reg <= i_reg + 1'b1;
                        if (mr == nm1_reg)
                        begin
                            pass_reg  <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else if (mr == one)
                            state_reg <= S_OUT;
                        else if (i_reg + 1'b1 >= k_reg)
                            state_reg <= S_OUT;
                        else
                            state_reg <= S_LSQ;
                    end
                end
                S_OUT:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign result.probable_prime = pass_reg;
    assign result.last_residue   = FW'(y_reg);

    // A result strobe comes only from the output state.
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == S_OUT)
        else $error("done without output state");
    // A pass never reports residue zero.
    a_pass_nz: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.probable_prime) |-> result.last_residue != '0)
        else $error("pass with zero residue");
    // Busy drops only together with a result strobe.
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy fell without result");
endmodule
`default_nettype wire
